/* rtl/iba_pkg.sv */
package iba_pkg;

    // Pool and inode table dimensions.
    localparam int BLK_CAP   = 32;
    localparam int INODE_CAP = 16;

    // Derived widths.
    localparam int BLK_W  = $clog2(BLK_CAP);
    localparam int CNT_W  = $clog2(BLK_CAP + 1);
    localparam int IDX_W  = $clog2(INODE_CAP);
    localparam int ICNT_W = $clog2(INODE_CAP + 1);
    localparam int LIST_DEPTH = INODE_CAP * BLK_CAP;

    // Field widths of the streams and the configuration register.
    localparam int CFG_W       = 6;
    localparam int SIZE_W      = 6;
    localparam int QUERY_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int INODE_W     = 4;
    localparam int BLOCK_W     = 5;
    localparam int POS_W       = 5;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TBL_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_INODE  = 2'd3;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_CREATE = 1'b0;
    localparam logic REQ_LIST   = 1'b1;

    // Which result the datapath loads into the output register.
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] EMIT_ERR_FULL  = 3'd0;
    localparam logic [KIND_W-1:0] EMIT_ERR_SPACE = 3'd1;
    localparam logic [KIND_W-1:0] EMIT_ERR_INODE = 3'd2;
    localparam logic [KIND_W-1:0] EMIT_EMPTY     = 3'd3;
    localparam logic [KIND_W-1:0] EMIT_ALLOC     = 3'd4;
    localparam logic [KIND_W-1:0] EMIT_LIST      = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_req;   // capture a new request
        logic              commit;     // take the next inode and record its size
        logic              emit;       // load the output register
        logic [KIND_W-1:0] emit_kind;
        logic              claim;      // mark the scanned block used and record it
        logic              skip;       // step the scan past a used block
        logic              list_first; // read the first list entry
        logic              list_next;  // advance the list and read the next entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_list;
        logic query_ok;
        logic list_empty;
        logic table_full;
        logic too_few;
        logic size_zero;
        logic bit_free;
        logic run_last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/iba_ram.sv */
module iba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds without a read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/iba_ctrl.sv */
module iba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  iba_pkg::t_sts i_sts,
    output iba_pkg::t_cmd o_cmd
);
    import iba_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_LIST   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    // Next state and commands; a result is only loaded when the output slot is free.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.out_free) begin
                    if (i_sts.is_list) begin
                        if (!i_sts.query_ok) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = EMIT_ERR_INODE;
                            n_state         = S_IDLE;
                        end else if (i_sts.list_empty) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = EMIT_EMPTY;
                            n_state         = S_IDLE;
                        end else begin
                            o_cmd.list_first = 1'b1;
                            n_state          = S_LIST;
                        end
                    end else begin
                        if (i_sts.table_full) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = EMIT_ERR_FULL;
                            n_state         = S_IDLE;
                        end else if (i_sts.too_few) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = EMIT_ERR_SPACE;
                            n_state         = S_IDLE;
                        end else if (i_sts.size_zero) begin
                            o_cmd.commit    = 1'b1;
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = EMIT_EMPTY;
                            n_state         = S_IDLE;
                        end else begin
                            o_cmd.commit = 1'b1;
                            n_state      = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (!i_sts.bit_free) begin
                    o_cmd.skip = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.claim     = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_ALLOC;
                    if (i_sts.run_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_LIST;
                    if (i_sts.run_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.list_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/iba_dp.sv */
module iba_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr,
    input  logic [iba_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_s_tuser,
    input  logic [iba_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  iba_pkg::t_cmd                   i_cmd,
    output iba_pkg::t_sts                   o_sts,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [iba_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);
    import iba_pkg::*;

    // Request registers.
    logic               r_type;
    logic [SIZE_W-1:0]  r_size;
    logic [QUERY_W-1:0] r_query;
    logic [IDX_W-1:0]   r_cur;

    // File system state.
    logic [BLK_CAP-1:0] r_used;
    logic [CNT_W-1:0]   r_free;
    logic [ICNT_W-1:0]  r_icount;
    logic [CNT_W-1:0]   r_isize [INODE_CAP];

    // Scan and position counters.
    logic [BLK_W-1:0] r_scan;
    logic [BLK_W-1:0] r_cnt;

    // Output register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [INODE_W-1:0]  r_out_inode;
    logic                r_out_bvalid;
    logic [BLOCK_W-1:0]  r_out_block;
    logic [POS_W-1:0]    r_out_pos;
    logic                r_out_last;

    logic [STATUS_W-1:0] n_out_status;
    logic [INODE_W-1:0]  n_out_inode;
    logic                n_out_bvalid;
    logic [BLOCK_W-1:0]  n_out_block;
    logic [POS_W-1:0]    n_out_pos;

    logic [CNT_W-1:0] cfg_pool;
    logic [CNT_W-1:0] run_len;
    logic [CNT_W-1:0] cnt_plus;
    logic             out_free;

    logic [BLK_W-1:0]        ram_rdata;
    logic [BLK_W-1:0]        rd_pos;
    logic [IDX_W+BLK_W-1:0]  ram_raddr;
    logic [IDX_W+BLK_W-1:0]  ram_waddr;

    // Pool size is the written value capped at the pool capacity.
    assign cfg_pool = (CNT_W'(i_cfg_data) > CNT_W'(BLK_CAP)) ? CNT_W'(BLK_CAP)
                                                            : CNT_W'(i_cfg_data);

    // Capture the request; a create takes the inode numbered by the current count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type  <= i_s_tuser;
            r_size  <= i_s_tdata[SIZE_W-1:0];
            r_query <= i_s_tdata[SIZE_W +: QUERY_W];
            r_cur   <= (i_s_tuser == REQ_LIST) ? IDX_W'(i_s_tdata[SIZE_W +: QUERY_W])
                                               : r_icount[IDX_W-1:0];
        end
    end

    // Bitmap, free count and inode count; a configuration write reinitializes them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_free   <= CNT_W'(BLK_CAP);
            r_icount <= '0;
        end else if (i_cfg_wr) begin
            r_used   <= '0;
            r_free   <= cfg_pool;
            r_icount <= '0;
        end else begin
            if (i_cmd.claim) begin
                r_used[r_scan] <= 1'b1;
                r_free         <= r_free - CNT_W'(1);
            end
            if (i_cmd.commit) begin
                r_icount <= r_icount + ICNT_W'(1);
            end
        end
    end

    // Inode sizes are written when an inode is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_isize[r_icount[IDX_W-1:0]] <= CNT_W'(r_size);
        end
    end

    // Scan pointer walks the bitmap; position counts blocks of the current file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.load_req) begin
            r_scan <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.claim || i_cmd.skip) begin
                r_scan <= r_scan + BLK_W'(1);
            end
            if (i_cmd.claim || i_cmd.list_next) begin
                r_cnt <= r_cnt + BLK_W'(1);
            end
        end
    end

    // Block lists live in a memory addressed by inode and position.
    assign rd_pos    = i_cmd.list_next ? (r_cnt + BLK_W'(1)) : r_cnt;
    assign ram_raddr = {r_cur, rd_pos};
    assign ram_waddr = {r_cur, r_cnt};

    iba_ram #(
        .WIDTH (BLK_W),
        .DEPTH (LIST_DEPTH)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.claim),
        .i_waddr (ram_waddr),
        .i_wdata (r_scan),
        .i_re    (i_cmd.list_first | i_cmd.list_next),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Last block of the run: position plus one reaches the file length.
    assign run_len  = (r_type == REQ_LIST) ? r_isize[r_cur] : CNT_W'(r_size);
    assign cnt_plus = CNT_W'(r_cnt) + CNT_W'(1);
    assign out_free = !r_out_valid || i_m_tready;

    // Status toward the controller.
    always_comb begin
        o_sts            = '0;
        o_sts.is_list    = (r_type == REQ_LIST);
        o_sts.query_ok   = (ICNT_W'(r_query) < r_icount);
        o_sts.list_empty = (r_isize[r_cur] == '0);
        o_sts.table_full = (r_icount == ICNT_W'(INODE_CAP));
        o_sts.too_few    = (CNT_W'(r_size) > r_free);
        o_sts.size_zero  = (r_size == '0);
        o_sts.bit_free   = !r_used[r_scan];
        o_sts.run_last   = (cnt_plus == run_len);
        o_sts.out_free   = out_free;
    end

    // Result fields by kind.
    always_comb begin
        n_out_status = ST_OK;
        n_out_inode  = '0;
        n_out_bvalid = 1'b0;
        n_out_block  = '0;
        n_out_pos    = '0;
        case (i_cmd.emit_kind)
            EMIT_ERR_FULL: begin
                n_out_status = ST_TBL_FULL;
            end
            EMIT_ERR_SPACE: begin
                n_out_status = ST_NO_SPACE;
            end
            EMIT_ERR_INODE: begin
                n_out_status = ST_NO_INODE;
                n_out_inode  = INODE_W'(r_query);
            end
            EMIT_EMPTY: begin
                n_out_inode = INODE_W'(r_cur);
            end
            EMIT_ALLOC: begin
                n_out_inode  = INODE_W'(r_cur);
                n_out_bvalid = 1'b1;
                n_out_block  = BLOCK_W'(r_scan);
                n_out_pos    = POS_W'(r_cnt);
            end
            EMIT_LIST: begin
                n_out_inode  = INODE_W'(r_cur);
                n_out_bvalid = 1'b1;
                n_out_block  = BLOCK_W'(ram_rdata);
                n_out_pos    = POS_W'(r_cnt);
            end
            default: begin
                n_out_status = ST_OK;
            end
        endcase
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload; single results are always last.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= n_out_status;
            r_out_inode  <= n_out_inode;
            r_out_bvalid <= n_out_bvalid;
            r_out_block  <= n_out_block;
            r_out_pos    <= n_out_pos;
            r_out_last   <= n_out_bvalid ? (cnt_plus == run_len) : 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_pos, r_out_block, r_out_bvalid,
                                      r_out_inode, r_out_status});

endmodule

/* rtl/indexed_block_allocator.sv */
// Indexed block allocator: first-fit bitmap over a pool of blocks plus an inode table.
// Input stream (s_*): one request per transaction. tuser is the request kind
// (0 create, 1 list); tdata carries request_size and query_inode.
// Output stream (m_*): one transaction per block created or listed, or a single
// transaction for an error or an empty file; tlast marks the final one.
// Configuration channel (cfg_*): writes blocks_in_pool, always ready; a write
// reinitializes the file system with the new pool size and must come while idle.
// Flow: a request is taken in the idle state and decided in the decide state,
// which waits for a free output register. A create then scans the bitmap one
// block per cycle, waiting on a free block while the output register is occupied.
// A list reads its first entry from the list memory and then gives one block per
// cycle while the output register is free. Single-result requests finish in the
// decide state. One request is processed at a time. The output register holds a
// finished result while the receiver stalls; the next request is accepted
// meanwhile, and work pauses only when a step needs the occupied output register.
// Reset (synchronous, active low) frees every block, sets the pool to 32 blocks
// and empties the inode table.
module indexed_block_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write: blocks_in_pool.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [iba_pkg::CFG_W-1:0]       i_cfg_data,
    // Request stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [iba_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // request_size, query_inode, zero pad
    input  logic                            i_s_tuser,  // req_type
    // Result stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [iba_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // status, inode_number, block_valid,
                                                        // block_index, position, zero pad
    output logic                            o_m_tlast   // last
);
    import iba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    iba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    iba_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // A result is only loaded when the output register can take it.
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded into an occupied output register");

    // Only a free block is ever claimed.
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.claim |-> sts.bit_free)
        else $error("claimed a block that is already used");

    // An inode is only taken when the table has room and enough blocks are free.
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !sts.table_full && !sts.too_few)
        else $error("inode taken for a request that does not fit");

    // Once a request is taken, no other is taken in the next cycle.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in progress");

endmodule

/* tb/sv/iba_alloc_check.sv */
// Watches the configuration, request and result channels of the allocator,
// predicts every result from its own copy of the bitmap and inode table, and
// compares each result transaction with the oldest prediction.
module iba_alloc_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [iba_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [iba_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // request_size, query_inode, zero pad
    input  logic                            i_s_tuser,  // req_type
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [iba_pkg::OUT_TDATA_W-1:0] i_m_tdata,  // status, inode_number, block_valid,
                                                        // block_index, position, zero pad
    input  logic                            i_m_tlast,  // last
    output int                              o_fail_count,
    output int                              o_pending
);
    import iba_pkg::*;

    // Bit offsets of the fields inside the streams.
    localparam int QUERY_LSB = SIZE_W;
    localparam int INODE_LSB = STATUS_W;
    localparam int VALID_LSB = INODE_LSB + INODE_W;
    localparam int BLOCK_LSB = VALID_LSB + 1;
    localparam int POS_LSB   = BLOCK_LSB + BLOCK_W;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INODE_W-1:0]  inode;
        logic                has_block;
        logic [BLOCK_W-1:0]  blk;
        logic [POS_W-1:0]    pos;
        logic                last;
    } t_blk_result;

    // Shadow file system.
    int                 pool_lim;
    logic [BLK_CAP-1:0] used_map;
    int                 free_left;
    int                 inodes_made;
    int                 file_len [INODE_CAP];
    logic [BLOCK_W-1:0] file_blocks [INODE_CAP][BLK_CAP];

    t_blk_result        expected_blocks [$];
    int                 mismatches = 0;

    // Wipes the file system for a given pool size, as reset and a register write do.
    task automatic format_fs(input logic [CFG_W-1:0] pool);
        pool_lim    = (int'(pool) < BLK_CAP) ? int'(pool) : BLK_CAP;
        used_map    = '0;
        free_left   = pool_lim;
        inodes_made = 0;
        for (int i = 0; i < INODE_CAP; i++) begin
            file_len[i] = 0;
        end
    endtask

    task automatic push_result(input logic [STATUS_W-1:0] st, input int ino, input logic vld,
                               input int blk, input int pos, input logic last);
        t_blk_result r;
        r.status    = st;
        r.inode     = INODE_W'(ino);
        r.has_block = vld;
        r.blk       = BLOCK_W'(blk);
        r.pos       = POS_W'(pos);
        r.last      = last;
        expected_blocks.push_back(r);
    endtask

    // Computes the results of one create or list request and updates the shadow state.
    task automatic allocate_or_list(input logic kind, input int size, input int query);
        int n;
        int cnt;
        if (kind == REQ_LIST) begin
            if (query >= inodes_made) begin
                push_result(ST_NO_INODE, query, 1'b0, 0, 0, 1'b1);
            end else if (file_len[query] == 0) begin
                push_result(ST_OK, query, 1'b0, 0, 0, 1'b1);
            end else begin
                for (int i = 0; i < file_len[query]; i++) begin
                    push_result(ST_OK, query, 1'b1, int'(file_blocks[query][i]), i,
                                (i + 1 == file_len[query]));
                end
            end
        end else if (inodes_made >= INODE_CAP) begin
            push_result(ST_TBL_FULL, 0, 1'b0, 0, 0, 1'b1);
        end else if (size > free_left) begin
            push_result(ST_NO_SPACE, 0, 1'b0, 0, 0, 1'b1);
        end else begin
            n = inodes_made;
            file_len[n] = size;
            inodes_made = n + 1;
            if (size == 0) begin
                push_result(ST_OK, n, 1'b0, 0, 0, 1'b1);
            end else begin
                // First fit: claim the lowest-numbered free blocks of the pool.
                cnt = 0;
                for (int b = 0; b < pool_lim && cnt < size; b++) begin
                    if (!used_map[b]) begin
                        used_map[b] = 1'b1;
                        file_blocks[n][cnt] = BLOCK_W'(b);
                        push_result(ST_OK, n, 1'b1, b, cnt, (cnt + 1 == size));
                        cnt++;
                    end
                end
                free_left -= cnt;
            end
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        t_blk_result want;
        if (expected_blocks.size() == 0) begin
            $error("result transaction with no request waiting: tdata %h", i_m_tdata);
            mismatches++;
        end else begin
            want = expected_blocks.pop_front();
            compare_field("status", want.status, i_m_tdata[INODE_LSB-1:0]);
            compare_field("inode_number", want.inode, i_m_tdata[VALID_LSB-1:INODE_LSB]);
            compare_field("block_valid", want.has_block, i_m_tdata[VALID_LSB]);
            compare_field("block_index", want.blk, i_m_tdata[POS_LSB-1:BLOCK_LSB]);
            compare_field("position", want.pos, i_m_tdata[POS_LSB+POS_W-1:POS_LSB]);
            compare_field("last", want.last, i_m_tlast);
        end
    endtask

    // Follow every transaction on the three channels.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            format_fs(CFG_W'(32));
            expected_blocks.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_result();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                format_fs(i_cfg_data);
            end
            if (i_s_tvalid && i_s_tready) begin
                allocate_or_list(i_s_tuser, int'(i_s_tdata[SIZE_W-1:0]),
                                 int'(i_s_tdata[QUERY_LSB+QUERY_W-1:QUERY_LSB]));
            end
        end
        o_pending    <= expected_blocks.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/sv/tb_top.sv */
// Drives create and list requests and pool-size writes into the allocator,
// with random gaps and result stalls, and reports the verdict of the checker.
module tb_top;
    import iba_pkg::*;

    localparam int IDLE_PCT    = 31;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 40;
    localparam int DRAIN_WAIT  = 40;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   steady    = 1'b0;
    int                     fail_count;
    int                     pending;
    int                     quiet_cycles = 0;

    indexed_block_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    iba_alloc_check alloc_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The result receiver stalls at random except during the steady phase.
    always @(posedge clk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Ends the run if no transaction moves on any channel for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is taken; tvalid stays high.
    task automatic send_request(input logic kind, input int size, input int query);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_TDATA_W'({QUERY_W'(query), SIZE_W'(size)});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Waits until every predicted result has been delivered and the block has settled.
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pool(input int blocks);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(blocks);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small creates so the inode table and pool fill at a useful pace.
    task automatic random_request();
        int pick;
        int size;
        pick = $urandom_range(99);
        if (pick < 55) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                size = $urandom_range(4);
            end else if (pick < 90) begin
                size = $urandom_range(12);
            end else begin
                size = $urandom_range(32);
            end
            send_request(REQ_CREATE, size, $urandom_range(15));
        end else begin
            send_request(REQ_LIST, $urandom_range(32), $urandom_range(15));
        end
    endtask

    initial begin
        int pool;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unknown inode, empty file, whole pool, no space, full table.
        send_request(REQ_LIST, 0, 0);
        send_request(REQ_CREATE, 0, 15);
        send_request(REQ_LIST, 32, 0);
        send_request(REQ_CREATE, 32, 0);
        send_request(REQ_CREATE, 1, 0);
        send_request(REQ_LIST, 0, 1);
        for (int i = 0; i < INODE_CAP - 2; i++) begin
            send_request(REQ_CREATE, 0, i);
        end
        send_request(REQ_CREATE, 1, 0);
        send_request(REQ_LIST, 0, 15);
        s_tvalid <= 1'b0;
        wait_drained();

        // Random phases, each on a freshly formatted pool.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       pool = 0;
                1:       pool = 32;
                2:       pool = 1;
                default: pool = $urandom_range(32);
            endcase
            steady = (p == 3);
            write_pool(pool);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_request();
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end
        steady = 1'b0;

        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
